// ----- hw/rtl/rsd_pkg.sv -----
// Shared types, codes and field layout for the rANS symbol decoder.
// Used by rsd_ctrl, rsd_dpath and rans_symbol_decoder; depends on nothing.
package rsd_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_M_EXP_DEF     = 12;
	localparam int WORD_BITS_DEF     = 16;

	// request kinds on the input stream
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_ENTRY  = 2'd1;
	localparam logic [1:0] CMD_WORD   = 2'd2;
	localparam logic [1:0] CMD_SUFFIX = 2'd3;

	// result status codes
	localparam logic [2:0] ST_ENTRY  = 3'd0;
	localparam logic [2:0] ST_WORD   = 3'd1;
	localparam logic [2:0] ST_SUFFIX = 3'd2;
	localparam logic [2:0] ST_DONE   = 3'd3;
	localparam logic [2:0] ST_ERROR  = 3'd4;
	localparam logic [2:0] ST_IDLE   = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_STATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_M_EXP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_M_EXP   = 2'd3;

	localparam logic [7:0] ESC_CODE = 8'd247;
	localparam logic [7:0] ESC_BIAS = 8'd239;

	// input tdata layout, lowest bit first
	localparam int IN_TDATA_W = 88;
	localparam int IN_CNT_LO  = 0;
	localparam int IN_SYM_LO  = 9;
	localparam int IN_CODE_LO = 29;
	localparam int IN_FD_LO   = 37;
	localparam int IN_WORD_LO = 53;
	localparam int IN_SFX_LO  = 69;

	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 4;

	typedef struct packed {
		logic [7:0]  root;
		logic [4:0]  len;
		logic [15:0] freq;
		logic [15:0] cum;
	} ent_t;

	typedef struct packed {
		logic       capture;
		logic       start;
		logic       entry;
		logic       word;
		logic       mul;
		logic       upd;
		logic       pick;
		logic       fill_rd;
		logic       fill_inc;
		logic       fill_wr;
		logic       slot_rd;
		logic       ent_rd;
		logic       take;
		logic       emit;
		logic [2:0] status;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       start_bad;
		logic       entries_last;
		logic       fill_adv;
		logic       fill_end;
		logic       below_lb;
		logic       no_symbols;
		logic       final_match;
		logic       out_free;
	} sts_t;

endpackage

// ----- hw/rtl/rsd_ctrl.sv -----
// Controller of the rANS symbol decoder: sequences request handling,
// table fill and renormalization. Depends on rsd_pkg.
module rsd_ctrl
	import rsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [3:0] S_WAIT  = 4'd0;
	localparam logic [3:0] S_UPD   = 4'd1;
	localparam logic [3:0] S_PICK  = 4'd2;
	localparam logic [3:0] S_FRD   = 4'd3;
	localparam logic [3:0] S_FCMP  = 4'd4;
	localparam logic [3:0] S_ADV   = 4'd5;
	localparam logic [3:0] S_ASLOT = 4'd6;
	localparam logic [3:0] S_AENT  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	localparam logic [1:0] PH_ENTRY  = 2'd0;
	localparam logic [1:0] PH_WORD   = 2'd1;
	localparam logic [1:0] PH_SUFFIX = 2'd2;
	localparam logic [1:0] PH_IDLE   = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [2:0] status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_WAIT;
			phase_q  <= PH_IDLE;
			status_q <= ST_IDLE;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		ctl        = '0;
		ctl.status = status_q;
		state_d    = state_q;
		phase_d    = phase_q;
		status_d   = status_q;
		in_ready   = 1'b0;
		case (state_q)
			S_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_EMIT;
					if (sts.cmd == CMD_START) begin
						if (sts.start_bad) begin
							status_d = ST_ERROR;
							phase_d  = PH_IDLE;
						end else begin
							ctl.start = 1'b1;
							status_d  = ST_ENTRY;
							phase_d   = PH_ENTRY;
						end
					end else if (phase_q == PH_IDLE) begin
						status_d = ST_IDLE;
					end else if (sts.cmd == CMD_ENTRY && phase_q == PH_ENTRY) begin
						ctl.entry = 1'b1;
						status_d  = ST_ENTRY;
						if (sts.entries_last)
							state_d = S_PICK;
					end else if (sts.cmd == CMD_WORD && phase_q == PH_WORD) begin
						ctl.word = 1'b1;
						state_d  = S_ADV;
					end else if (sts.cmd == CMD_SUFFIX && phase_q == PH_SUFFIX) begin
						ctl.mul = 1'b1;
						state_d = S_UPD;
					end else begin
						status_d = ST_ERROR;
						phase_d  = PH_IDLE;
					end
				end
			end
			S_UPD: begin
				ctl.upd = 1'b1;
				state_d = S_ADV;
			end
			S_PICK: begin
				ctl.pick = 1'b1;
				state_d  = S_FRD;
			end
			S_FRD: begin
				ctl.fill_rd = 1'b1;
				state_d     = S_FCMP;
			end
			S_FCMP: begin
				// step to the next entry, or write this slot
				if (sts.fill_adv) begin
					ctl.fill_inc = 1'b1;
					state_d      = S_FRD;
				end else begin
					ctl.fill_wr = 1'b1;
					if (sts.fill_end)
						state_d = S_ADV;
				end
			end
			S_ADV: begin
				if (sts.below_lb) begin
					status_d = ST_WORD;
					phase_d  = PH_WORD;
					state_d  = S_EMIT;
				end else if (sts.no_symbols) begin
					status_d = sts.final_match ? ST_DONE : ST_ERROR;
					phase_d  = PH_IDLE;
					state_d  = S_EMIT;
				end else begin
					ctl.slot_rd = 1'b1;
					state_d     = S_ASLOT;
				end
			end
			S_ASLOT: begin
				ctl.ent_rd = 1'b1;
				state_d    = S_AENT;
			end
			S_AENT: begin
				ctl.take = 1'b1;
				status_d = ST_SUFFIX;
				phase_d  = PH_SUFFIX;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_WAIT;
				end
			end
			default: begin
				state_d = S_WAIT;
			end
		endcase
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> !in_ready)
		else $error("request taken while previous one in work");

	a_mul_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul |=> ctl.upd)
		else $error("state update does not follow multiply");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("result overwrites an untaken one");

endmodule

// ----- hw/rtl/rsd_dpath.sv -----
// Datapath of the rANS symbol decoder: coder state, entry and slot memories,
// exponent pick, multiply-add and output register. Depends on rsd_pkg.
module rsd_dpath
	import rsd_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_M_EXP     = MAX_M_EXP_DEF,
	parameter int WORD_BITS     = WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  logic [1:0]             in_user,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic [OUT_TUSER_W-1:0] out_user,
	output logic                   out_last,
	input  ctl_t                   ctl,
	output sts_t                   sts
);

	localparam int ENTRY_AW   = $clog2(TABLE_ENTRIES);
	localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
	localparam int TOT_W      = 16 + ENTRY_AW;
	localparam int SLOT_IW    = MAX_M_EXP;
	localparam int SLOT_AW    = MAX_M_EXP + 1;
	localparam int SLOT_DEPTH = (1 << MAX_M_EXP) + 1;

	// configuration
	logic [31:0] lower_bound_q, final_state_q;
	logic [3:0]  min_exp_q, max_exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= 32'd65536;
			final_state_q <= 32'd65536;
			min_exp_q     <= 4'd8;
			max_exp_q     <= 4'd12;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER_BOUND: lower_bound_q <= cfg_data;
				REG_FINAL_STATE: final_state_q <= cfg_data;
				REG_MIN_M_EXP:   min_exp_q     <= cfg_data[3:0];
				REG_MAX_M_EXP:   max_exp_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic [8:0]  f_cnt;
	logic [19:0] f_sym;
	logic [7:0]  f_code;
	logic [15:0] f_delta, f_word, f_sfx;

	assign f_cnt   = in_data[IN_CNT_LO +: 9];
	assign f_sym   = in_data[IN_SYM_LO +: 20];
	assign f_code  = in_data[IN_CODE_LO +: 8];
	assign f_delta = in_data[IN_FD_LO +: 16];
	assign f_word  = in_data[IN_WORD_LO +: 16];
	assign f_sfx   = in_data[IN_SFX_LO +: 16];

	logic [31:0]         state_q;
	logic [TOT_W-1:0]    total_q;
	logic [3:0]          mexp_q;
	logic [CNT_W-1:0]    n_q, left_q;
	logic [19:0]         syms_q;
	logic [ENTRY_AW-1:0] wr_idx_q, u_q, slot_rd_q;
	logic [15:0]         prev_q;
	logic [SLOT_AW-1:0]  pos_q;
	logic [31:0]         prod_s1;
	ent_t                ent_rd_q;
	logic [4:0]          bits_q;
	logic [15:0]         value_q;
	logic                vvalid_q, last_q;

	ent_t ent_mem [TABLE_ENTRIES];
	logic [ENTRY_AW-1:0] slot_mem [SLOT_DEPTH];

	// new entry
	logic [15:0] new_freq;
	ent_t        ent_wr;

	always_comb begin
		new_freq = (wr_idx_q == '0) ? f_delta : prev_q - f_delta;
		if (f_code < ESC_CODE) begin
			ent_wr.root = f_code;
			ent_wr.len  = 5'd0;
		end else begin
			ent_wr.root = 8'd0;
			ent_wr.len  = 5'(f_code - ESC_BIAS);
		end
		ent_wr.freq = new_freq;
		ent_wr.cum  = total_q[15:0];
	end

	// nearest power of two to the total, then clamped
	logic [4:0] e_raw, e_a, e_b, e_c;
	logic [3:0] top_bit;

	always_comb begin
		top_bit = 4'd0;
		for (int b = 1; b < 16; b++) begin
			if (total_q[b])
				top_bit = 4'(b);
		end
		if (total_q[TOT_W-1:16] != '0)
			e_raw = 5'd16;
		else if (total_q[15:1] == '0)
			e_raw = 5'd0;
		else
			e_raw = {1'b0, top_bit} + {4'd0, total_q[top_bit - 4'd1]};
		e_a = (e_raw > {1'b0, max_exp_q}) ? {1'b0, max_exp_q} : e_raw;
		e_b = (e_a < {1'b0, min_exp_q}) ? {1'b0, min_exp_q} : e_a;
		e_c = (e_b > 5'(MAX_M_EXP)) ? 5'(MAX_M_EXP) : e_b;
	end

	// symbol arithmetic
	logic [SLOT_IW-1:0]  slot_mask, slot_idx;
	logic [31:0]         state_shr;
	logic [47:0]         prod_full;
	logic [15:0]         sfx_mask;
	logic [ENTRY_AW-1:0] ent_rd_addr;
	logic                ent_rd_en;

	assign slot_mask   = ~({SLOT_IW{1'b1}} << mexp_q);
	assign slot_idx    = state_q[SLOT_IW-1:0] & slot_mask;
	assign state_shr   = state_q >> mexp_q;
	assign prod_full   = ent_rd_q.freq * state_shr;
	assign sfx_mask    = (ent_rd_q.len >= 5'd16) ? 16'hFFFF : ~(16'hFFFF << ent_rd_q.len);
	assign ent_rd_addr = ctl.fill_rd ? ENTRY_AW'(u_q + 1'b1) : slot_rd_q;
	assign ent_rd_en   = ctl.fill_rd | ctl.ent_rd;

	always_ff @(posedge clk) begin
		if (ctl.entry)
			ent_mem[wr_idx_q] <= ent_wr;
		if (ent_rd_en)
			ent_rd_q <= ent_mem[ent_rd_addr];
		if (ctl.fill_wr)
			slot_mem[pos_q] <= u_q;
		if (ctl.slot_rd)
			slot_rd_q <= slot_mem[{1'b0, slot_idx}];
		if (ctl.mul)
			prod_s1 <= prod_full[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			total_q   <= '0;
			mexp_q    <= '0;
			n_q       <= '0;
			left_q    <= '0;
			syms_q    <= '0;
			wr_idx_q  <= '0;
			u_q       <= '0;
			prev_q    <= '0;
			pos_q     <= '0;
			bits_q    <= '0;
			value_q   <= '0;
			vvalid_q  <= 1'b0;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
			out_data  <= '0;
			out_user  <= '0;
			out_last  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				bits_q   <= '0;
				value_q  <= '0;
				vvalid_q <= 1'b0;
				last_q   <= 1'b0;
			end
			if (ctl.start) begin
				n_q      <= CNT_W'(f_cnt);
				left_q   <= CNT_W'(f_cnt);
				syms_q   <= f_sym;
				wr_idx_q <= '0;
				total_q  <= '0;
				state_q  <= '0;
			end
			if (ctl.entry) begin
				total_q  <= total_q + TOT_W'(new_freq);
				prev_q   <= new_freq;
				wr_idx_q <= wr_idx_q + 1'b1;
				left_q   <= left_q - 1'b1;
			end
			if (ctl.word)
				state_q <= (state_q << WORD_BITS) | 32'(f_word[WORD_BITS-1:0]);
			if (ctl.mul) begin
				value_q  <= 16'({8'd0, ent_rd_q.root} + (f_sfx & sfx_mask));
				vvalid_q <= 1'b1;
				last_q   <= (syms_q == 20'd1);
				syms_q   <= syms_q - 1'b1;
			end
			if (ctl.upd)
				state_q <= prod_s1 + 32'(slot_idx) - 32'(ent_rd_q.cum);
			if (ctl.pick) begin
				mexp_q <= e_c[3:0];
				u_q    <= '0;
				pos_q  <= '0;
			end
			if (ctl.fill_inc)
				u_q <= u_q + 1'b1;
			if (ctl.fill_wr)
				pos_q <= pos_q + 1'b1;
			if (ctl.take)
				bits_q <= ent_rd_q.len;
			// hold a result until taken
			if (ctl.emit) begin
				out_valid <= 1'b1;
				out_data  <= {3'd0, value_q, bits_q};
				out_user  <= {vvalid_q, ctl.status};
				out_last  <= last_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.cmd          = in_user;
		sts.start_bad    = (f_cnt == 9'd0) || ({1'b0, f_cnt} > 10'(TABLE_ENTRIES))
			|| (f_sym == 20'd0);
		sts.entries_last = (left_q == CNT_W'(1));
		sts.fill_adv     = ((CNT_W'(u_q) + CNT_W'(1)) < n_q)
			&& (16'(pos_q) >= ent_rd_q.cum);
		sts.fill_end     = (pos_q == (SLOT_AW'(1) << mexp_q));
		sts.below_lb     = (state_q < lower_bound_q);
		sts.no_symbols   = (syms_q == 20'd0);
		sts.final_match  = (state_q == final_state_q);
		sts.out_free     = !out_valid || out_ready;
	end

endmodule

// ----- hw/rtl/rans_symbol_decoder.sv -----
// Top level of the rANS symbol decoder: stream ports, config port,
// controller and datapath. Depends on rsd_pkg, rsd_ctrl and rsd_dpath.
//
// channel   dir  tdata (low bit up)                         tuser / tlast
// s_axis    in   entry_count, symbol_count, code,           tuser: cmd
//                freq_delta, word, suffix (85 of 88 bits)
// m_axis    out  suffix_bits, value (21 of 24 bits)         tuser: status, value_valid
//                                                           tlast: last
// cfg       in   cfg_we, cfg_index, cfg_data                write only
//
// One request at a time. The last entry adds the table fill in the controller loop:
// each entry skipped takes a read step and a compare step, each slot a write step,
// M+1 slots. Renormalization and lookup read the slot memory, then the entry memory.
// arst_n clears control state; memories are not cleared. A stalled result holds
// the block in its emit step until m_axis_tready.
module rans_symbol_decoder
	import rsd_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_M_EXP     = MAX_M_EXP_DEF,
	parameter int WORD_BITS     = WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_count, symbol_count, code,
	                                              // freq_delta, word, suffix
	input  logic [1:0]             s_axis_tuser,  // cmd
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // suffix_bits, value
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // status, value_valid
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ctl_t ctl;
	sts_t sts;

	rsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	rsd_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_M_EXP     (MAX_M_EXP),
		.WORD_BITS     (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

// ----- tb/rans_symbol_decoder_tb.sv -----
// Self-checking testbench for rans_symbol_decoder: a directed table, then random
// decode blocks, checked against the rows or a decoder model. Depends on rsd_pkg.
module rans_symbol_decoder_tb;
	import rsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  bits;
		logic [15:0] value;
		logic        valid;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [8:0]  cnt;
		logic [19:0] sym;
		logic [7:0]  code;
		logic [15:0] fd;
		logic [15:0] word;
		logic [15:0] sfx;
		logic        typed;
		res_t        want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = CMD_START;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_LOWER_BOUND;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	rans_symbol_decoder DUT (.*);

	always #1 clk = ~clk;

	// decoder model state
	logic [31:0] lb_reg = 32'd65536, fin_reg = 32'd65536;
	logic [3:0]  min_exp = 4'd8, max_exp = 4'd12;
	logic [7:0]  root_mem [256];
	logic [4:0]  len_mem [256];
	logic [15:0] freq_mem [256];
	logic [15:0] cum_mem [256];
	logic [7:0]  slot_mem [4097];
	logic [31:0] coder_st = '0, freq_sum = '0;
	int unsigned m_exp = 0, ents_left = 0, ents_total = 0, cur_ent = 0;
	logic [19:0] syms_left = '0;
	logic [2:0]  phase = ST_IDLE;

	res_t        pending_results [$];
	int          errors = 0;
	int          sent = 0;
	bit          calm = 1'b0;
	logic [2:0]  next_need = ST_IDLE;

	function automatic int unsigned nearest_exp(logic [31:0] t);
		int unsigned f = 0, e;
		logic [31:0] p, d;
		if (t <= 32'd1) e = 0;
		else begin
			while (f < 31 && (t >> (f + 1)) != 0) f++;
			p = 32'd1 << f;
			d = t - p;
			e = (d < p - d) ? f : f + 1;
		end
		if (e > max_exp) e = max_exp;
		if (e < min_exp) e = min_exp;
		if (e > 12) e = 12;
		return e;
	endfunction

	function automatic void fill_slots();
		int unsigned m, pos = 0;
		m_exp = nearest_exp(freq_sum);
		m = 1 << m_exp;
		for (int unsigned u = 0; u + 1 < ents_total; u++)
			while (pos <= m && pos < cum_mem[u + 1]) begin
				slot_mem[pos] = u[7:0];
				pos++;
			end
		while (pos <= m) begin
			slot_mem[pos] = 8'(ents_total - 1);
			pos++;
		end
	endfunction

	// choose the next request after a state change
	function automatic void next_step(inout res_t r);
		r.bits = '0;
		if (coder_st < lb_reg) begin
			phase = ST_WORD;
			r.status = ST_WORD;
		end else if (syms_left == 0) begin
			phase = ST_IDLE;
			r.status = (coder_st == fin_reg) ? ST_DONE : ST_ERROR;
		end else begin
			cur_ent = slot_mem[coder_st & ((32'd1 << m_exp) - 1)];
			phase = ST_SUFFIX;
			r.bits = len_mem[cur_ent];
			r.status = ST_SUFFIX;
		end
	endfunction

	function automatic res_t decode_step(logic [1:0] cmd, logic [IN_TDATA_W-1:0] d);
		res_t r = '0;
		logic [8:0]  n = d[IN_CNT_LO +: 9];
		logic [19:0] s = d[IN_SYM_LO +: 20];
		logic [7:0]  code = d[IN_CODE_LO +: 8];
		logic [15:0] delta = d[IN_FD_LO +: 16];
		logic [15:0] f, mask, sfx;
		logic [31:0] slot;
		int unsigned i;
		if (cmd == CMD_START) begin
			if (n == 0 || n > 256 || s == 0) begin
				phase = ST_IDLE;
				r.status = ST_ERROR;
			end else begin
				ents_total = n;
				ents_left = n;
				syms_left = s;
				cur_ent = 0;
				freq_sum = '0;
				coder_st = '0;
				phase = ST_ENTRY;
				r.status = ST_ENTRY;
			end
		end else if (phase == ST_IDLE) begin
			r.status = ST_IDLE;
		end else if (cmd == CMD_ENTRY && phase == ST_ENTRY) begin
			i = cur_ent & 255;
			f = (i == 0) ? delta : freq_mem[(i - 1) & 255] - delta;
			root_mem[i] = (code < ESC_CODE) ? code : 8'd0;
			len_mem[i] = (code < ESC_CODE) ? 5'd0 : 5'(code - ESC_BIAS);
			freq_mem[i] = f;
			cum_mem[i] = freq_sum[15:0];
			freq_sum = freq_sum + f;
			cur_ent = (i + 1) & 255;
			ents_left--;
			if (ents_left == 0) begin
				fill_slots();
				next_step(r);
			end else r.status = ST_ENTRY;
		end else if (cmd == CMD_WORD && phase == ST_WORD) begin
			coder_st = (coder_st << 16) | d[IN_WORD_LO +: 16];
			next_step(r);
		end else if (cmd == CMD_SUFFIX && phase == ST_SUFFIX) begin
			i = cur_ent & 255;
			mask = (len_mem[i] >= 16) ? 16'hFFFF : 16'((32'd1 << len_mem[i]) - 1);
			sfx = d[IN_SFX_LO +: 16] & mask;
			slot = coder_st & ((32'd1 << m_exp) - 1);
			r.value = root_mem[i] + sfx;
			r.valid = 1'b1;
			coder_st = freq_mem[i] * (coder_st >> m_exp) + slot - cum_mem[i];
			syms_left--;
			r.last = (syms_left == 0);
			next_step(r);
		end else begin
			phase = ST_IDLE;
			r.status = ST_ERROR;
		end
		return r;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] make_item(logic [8:0] cnt, logic [19:0] sym,
			logic [7:0] code, logic [15:0] fd, logic [15:0] word, logic [15:0] sfx);
		logic [IN_TDATA_W-1:0] d = IN_TDATA_W'({$urandom(), $urandom(), $urandom()});
		d[IN_TDATA_W-1:85] = '0;
		d[IN_CNT_LO +: 9] = cnt;
		d[IN_SYM_LO +: 20] = sym;
		d[IN_CODE_LO +: 8] = code;
		d[IN_FD_LO +: 16] = fd;
		d[IN_WORD_LO +: 16] = word;
		d[IN_SFX_LO +: 16] = sfx;
		return d;
	endfunction

	task automatic issue(input logic [1:0] cmd, input logic [IN_TDATA_W-1:0] d,
			input logic typed, input res_t want);
		res_t r;
		if (!calm && $urandom_range(0, 99) < 32) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		r = decode_step(cmd, d);
		pending_results.push_back(typed ? want : r);
		next_need = r.status;
		sent++;
	endtask

	task automatic rand_item(input logic [1:0] cmd, input logic [15:0] fd, input logic [7:0] code);
		issue(cmd, make_item(9'($urandom_range(1, 256)), 20'($urandom()), code, fd,
			16'($urandom()), 16'($urandom())), 1'b0, '0);
	endtask

	// hold off until every request has its result, then write all registers
	task automatic set_regs(input logic [31:0] lb, input logic [31:0] fin,
			input logic [3:0] mn, input logic [3:0] mx);
		logic [31:0] vals [4];
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		vals = '{lb, fin, {28'd0, mn}, {28'd0, mx}};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lb_reg = lb;
		fin_reg = fin;
		min_exp = mn;
		max_exp = mx;
	endtask

	// one block, mostly well formed, abandoned after a bounded number of requests
	task automatic decode_block();
		int unsigned n, syms, steps = 0;
		logic [15:0] prev = '0, f;
		bit first = 1'b1;
		logic [7:0] code;
		n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) :
			($urandom_range(0, 99) < 90) ? $urandom_range(7, 40) : $urandom_range(250, 256);
		syms = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20'hFFFFF) : $urandom_range(1, 6);
		issue(CMD_START, make_item(9'(n), 20'(syms), 8'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom())), 1'b0, '0);
		while (steps < n + 50 && (next_need == ST_ENTRY || next_need == ST_WORD ||
				next_need == ST_SUFFIX)) begin
			steps++;
			if ($urandom_range(0, 99) < 3) begin
				rand_item(2'($urandom()), 16'($urandom()), 8'($urandom()));
			end else if (next_need == ST_ENTRY) begin
				case ($urandom_range(0, 19))
					0: f = 16'($urandom());
					1: f = '0;
					default: f = 16'($urandom_range(1, 64));
				endcase
				code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(247, 255)) : 8'($urandom());
				rand_item(CMD_ENTRY, first ? f : prev - f, code);
				prev = f;
				first = 1'b0;
			end else if (next_need == ST_WORD) begin
				rand_item(CMD_WORD, 16'($urandom()), 8'($urandom()));
			end else begin
				rand_item(CMD_SUFFIX, 16'($urandom()), 8'($urandom()));
			end
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);

	always @(posedge clk) begin
		res_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%h", $time, m_axis_tdata,
					m_axis_tuser);
				errors++;
			end else begin
				w = pending_results.pop_front();
				if (m_axis_tuser[2:0] !== w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, w.status,
						m_axis_tuser[2:0]);
					errors++;
				end
				if (m_axis_tdata[4:0] !== w.bits) begin
					$display("%0t: suffix_bits expected %0d actual %0d", $time, w.bits,
						m_axis_tdata[4:0]);
					errors++;
				end
				if (m_axis_tdata[20:5] !== w.value) begin
					$display("%0t: value expected %h actual %h", $time, w.value,
						m_axis_tdata[20:5]);
					errors++;
				end
				if (m_axis_tuser[3] !== w.valid) begin
					$display("%0t: value_valid expected %b actual %b", $time, w.valid,
						m_axis_tuser[3]);
					errors++;
				end
				if (m_axis_tlast !== w.last) begin
					$display("%0t: last expected %b actual %b", $time, w.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t tab [23];
		tab = '{
			'{CMD_ENTRY,  9'd1,   20'd1,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_IDLE, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd0,   20'd1,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd257, 20'd1,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd1,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd511, 20'hFFFFF,   8'hFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd2,   20'd3,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ENTRY, 5'd0, 16'd0, 1'b0, 1'b0}},
			// wrong kind inside a block aborts it
			'{CMD_WORD,   9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_SUFFIX, 9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_IDLE, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_START,  9'd1,   20'd1,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ENTRY, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_ENTRY,  9'd0,   20'd0,       8'd250, 16'd256,   16'd0,     16'd0,     1'b1,
				'{ST_WORD, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_WORD,   9'd0,   20'd0,       8'd0,   16'd0,     16'd1,     16'd0,     1'b1,
				'{ST_WORD, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_WORD,   9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_SUFFIX, 5'd11, 16'd0, 1'b0, 1'b0}},
			'{CMD_SUFFIX, 9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'hFFFF,  1'b1,
				'{ST_DONE, 5'd0, 16'd2047, 1'b1, 1'b1}},
			'{CMD_START,  9'd2,   20'd2,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ENTRY, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_ENTRY,  9'd0,   20'd0,       8'd246, 16'hFFFF,  16'd0,     16'd0,     1'b1,
				'{ST_ENTRY, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_ENTRY,  9'd0,   20'd0,       8'd255, 16'd0,     16'd0,     16'd0,     1'b0, '0},
			'{CMD_WORD,   9'd0,   20'd0,       8'd0,   16'd0,     16'hFFFF,  16'd0,     1'b0, '0},
			'{CMD_WORD,   9'd0,   20'd0,       8'd0,   16'd0,     16'h8000,  16'd0,     1'b0, '0},
			'{CMD_SUFFIX, 9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'hFFFF,  1'b0, '0},
			// start in the middle of a block
			'{CMD_START,  9'd3,   20'd5,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ENTRY, 5'd0, 16'd0, 1'b0, 1'b0}},
			'{CMD_ENTRY,  9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b0, '0},
			'{CMD_ENTRY,  9'd0,   20'd0,       8'd247, 16'd0,     16'd0,     16'd0,     1'b0, '0},
			'{CMD_SUFFIX, 9'd0,   20'd0,       8'd0,   16'd0,     16'd0,     16'd0,     1'b1,
				'{ST_ERROR, 5'd0, 16'd0, 1'b0, 1'b0}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tab[k]) begin
			logic [IN_TDATA_W-1:0] d;
			d = '0;
			d[IN_CNT_LO +: 9] = tab[k].cnt;
			d[IN_SYM_LO +: 20] = tab[k].sym;
			d[IN_CODE_LO +: 8] = tab[k].code;
			d[IN_FD_LO +: 16] = tab[k].fd;
			d[IN_WORD_LO +: 16] = tab[k].word;
			d[IN_SFX_LO +: 16] = tab[k].sfx;
			issue(tab[k].cmd, d, tab[k].typed, tab[k].want);
		end
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(32'd1, 32'd0, 4'd0, 4'd1);
				1: set_regs(32'h8000_0000, 32'hFFFF_FFFF, 4'd12, 4'd12);
				2: set_regs(32'd65536, $urandom(), 4'd10, 4'd3);
				3: set_regs($urandom_range(1, 32'h0100_0000), $urandom(), 4'd4, 4'd9);
				4: set_regs(32'd256, $urandom(), 4'd0, 4'd12);
				default: set_regs(32'd65536, 32'd65536, 4'd8, 4'd12);
			endcase
			while (sent < 23 + (ph + 1) * 240) begin
				calm = (sent >= 700 && sent < 850);
				// noise between blocks: stray requests, mostly while idle, and bad starts
				if ($urandom_range(0, 9) == 0)
					rand_item(2'($urandom_range(1, 3)), 16'($urandom()), 8'($urandom()));
				if ($urandom_range(0, 19) == 0)
					issue(CMD_START, make_item(($urandom_range(0, 1) ? 9'd0 : 9'(
						$urandom_range(257, 511))), 20'($urandom()), 8'($urandom()),
						16'($urandom()), 16'($urandom()), 16'($urandom())), 1'b0, '0);
				decode_block();
			end
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// any block may end a table and walk all slots, under output stalls
	initial begin
		#100000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_ctrl.sv
hw/rtl/rsd_dpath.sv
hw/rtl/rans_symbol_decoder.sv
tb/rans_symbol_decoder_tb.sv
